/* rtl/lfrx_pkg.sv */
// Package for the LED frame serial receiver.
// Holds shared constants, register indexes and the types passed between the
// front queue, the back sequencer and the top level.
package lfrx_pkg;

  localparam int LED_COUNT_DEF = 224;

  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_TICK = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_D       = 8'h64;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHECK_XOR    = 8'h55;

  localparam logic [15:0] TIMEOUT_RST = 16'd2500;
  localparam logic [7:0]  RED_RST     = 8'd40;
  localparam logic [7:0]  GREEN_RST   = 8'd20;
  localparam logic [7:0]  BLUE_RST    = 8'd80;

  typedef enum logic [1:0] {
    CFG_TIMEOUT = 2'd0,
    CFG_RED     = 2'd1,
    CFG_GREEN   = 2'd2,
    CFG_BLUE    = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OP_BYTE,
    OP_TICK,
    OP_READ,
    OP_NOP
  } op_t;

  typedef struct packed {
    logic [15:0] timeout_ms;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } cfg_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic [9:0] index;
  } cmd_t;

  typedef struct packed {
    logic init;
    logic fill;
  } status_t;

endpackage

/* rtl/led_frame_serial_receiver_core.sv */
// Top level of the LED frame serial receiver.
// Holds the configuration registers and joins lfrx_front and lfrx_back.
// Uses lfrx_pkg.
//
// The slave stream carries one item per beat: serial bytes, millisecond
// ticks and reads of the LED byte store, selected by s_tuser. Every accepted
// beat gives exactly one beat on the master stream with the show pulse, the
// fallback flag, the receiving flag and the byte read from the store.
// A two-entry queue sits between the input decoder and the back end, and
// the result waits in an output register, so either side may stall alone.
// A read inside the store passes through the S_READ state for the registered
// RAM read; bytes, ticks, unused kinds and reads past the store do not. A
// timeout that shows the fallback colour starts a fill of all 3*LED_COUNT
// bytes of the store, one byte per cycle through the single write port;
// later items wait in the queue meanwhile. After reset the same pass loads
// the reset fallback colour, and s_tready stays low until it is done.
// Configuration writes are taken at any time and should be made while idle.
module led_frame_serial_receiver_core
  import lfrx_pkg::*;
#(
  parameter int LED_COUNT = LED_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // serial_byte[7:0], read_index[17:8], zero pad
  input  logic [1:0]  s_tuser,   // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // show[0], fallback_active[1], receiving[2],
                                 // read_byte[10:3], zero pad
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t       cfg;
  status_t    status;
  logic       q_valid;
  cmd_t       q_cmd;
  logic       q_pop;
  logic       show;
  logic       fallback_active;
  logic       receiving;
  logic [7:0] read_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ms <= TIMEOUT_RST;
      cfg.red        <= RED_RST;
      cfg.green      <= GREEN_RST;
      cfg.blue       <= BLUE_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TIMEOUT: cfg.timeout_ms <= cfg_data;
        CFG_RED:     cfg.red        <= cfg_data[7:0];
        CFG_GREEN:   cfg.green      <= cfg_data[7:0];
        CFG_BLUE:    cfg.blue       <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  lfrx_front u_front (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .status  (status),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop)
  );

  lfrx_back #(
    .LED_COUNT(LED_COUNT)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_pop        (q_pop),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_show     (show),
    .out_fallback (fallback_active),
    .out_receiving(receiving),
    .out_read     (read_byte),
    .status       (status)
  );

  assign m_tdata = {5'd0, read_byte, receiving, fallback_active, show};

`ifndef SYNTHESIS
  a_no_accept_during_init : assert property (@(posedge clk) disable iff (rst)
    status.init |-> !s_tready)
    else $error("input accepted during the reset fill of the store");

  a_fill_starts_with_show : assert property (@(posedge clk) disable iff (rst)
    (status.fill && !status.init && !$past(status.fill))
      |-> (m_tvalid && m_tdata[0] && m_tdata[1]))
    else $error("fallback fill started without a show result");
`endif

endmodule

/* rtl/lfrx_ram.sv */
// Generic simple dual-port RAM with registered read.
// One write port and one read port; no dependencies.
module lfrx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 672,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/lfrx_front.sv */
// Front end of the LED frame receiver: accepts input beats, decodes the kind
// into a command and holds up to two commands for the back end. Uses lfrx_pkg.
module lfrx_front
  import lfrx_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  status_t     status,
  output logic        q_valid,
  output cmd_t        q_cmd,
  input  logic        q_pop
);

  cmd_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] level;
  cmd_t       cmd_in;
  logic       push;

  always_comb begin
    cmd_in.data  = s_tdata[7:0];
    cmd_in.index = s_tdata[17:8];
    case (s_tuser)
      KIND_BYTE: cmd_in.op = OP_BYTE;
      KIND_TICK: cmd_in.op = OP_TICK;
      KIND_READ: cmd_in.op = OP_READ;
      default:   cmd_in.op = OP_NOP;
    endcase
  end

  assign s_tready = (level != 2'd2) && !status.init;
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (level != 2'd0);
  assign q_cmd    = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      level  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !q_pop) begin
        level <= level + 2'd1;
      end else if (!push && q_pop) begin
        level <= level - 2'd1;
      end
    end
  end

endmodule

/* rtl/lfrx_back.sv */
// Back end of the LED frame receiver: frame parser, idle timer, LED store
// with its fill sequencer, and the output register. Uses lfrx_pkg and lfrx_ram.
module lfrx_back
  import lfrx_pkg::*;
#(
  parameter int LED_COUNT = LED_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       q_valid,
  input  cmd_t       q_cmd,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_show,
  output logic       out_fallback,
  output logic       out_receiving,
  output logic [7:0] out_read,
  output status_t    status
);

  localparam int STORE_BYTES = 3 * LED_COUNT;
  localparam int AW          = $clog2(STORE_BYTES);

  typedef enum logic [1:0] {
    S_RUN,
    S_READ,
    S_FILL
  } state_t;

  typedef enum logic [2:0] {
    PH_WAIT_A  = 3'd0,
    PH_WAIT_D  = 3'd1,
    PH_WAIT_A2 = 3'd2,
    PH_HIGH    = 3'd3,
    PH_LOW     = 3'd4,
    PH_CHECK   = 3'd5,
    PH_DATA    = 3'd6
  } phase_t;

  state_t      state, state_next;
  phase_t      phase, phase_next;
  logic [7:0]  count_high, count_high_next;
  logic [7:0]  count_low, count_low_next;
  logic [17:0] frame_bytes, frame_bytes_next;
  logic [17:0] data_position, data_position_next;
  logic [15:0] idle_ms, idle_ms_next;
  logic        in_fallback, in_fallback_next;
  logic [AW-1:0] fill_addr, fill_addr_next;
  logic [1:0]  fill_ch, fill_ch_next;
  logic        fill_init, fill_init_next;
  logic        out_valid_next, out_show_next, out_fallback_next, out_receiving_next;
  logic [7:0]  out_read_next;

  logic          take;
  logic          done;
  logic          fire;
  logic          rd_in_range;
  logic [16:0]   count_plus;
  logic [17:0]   pos_inc;
  logic [7:0]    fill_colour;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  lfrx_ram #(
    .WIDTH(8),
    .DEPTH(STORE_BYTES),
    .AW   (AW)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign take        = (state == S_RUN) && q_valid && (!out_valid || out_ready);
  assign q_pop       = take;
  assign rd_in_range = 32'(q_cmd.index) < STORE_BYTES;
  assign count_plus  = {1'b0, count_high, count_low} + 17'd1;
  assign pos_inc     = data_position + 18'd1;
  assign ram_raddr   = AW'(q_cmd.index);
  assign status.init = fill_init;
  assign status.fill = (state == S_FILL);

  always_comb begin
    case (fill_ch)
      2'd0:    fill_colour = fill_init ? RED_RST : cfg.red;
      2'd1:    fill_colour = fill_init ? GREEN_RST : cfg.green;
      default: fill_colour = fill_init ? BLUE_RST : cfg.blue;
    endcase
  end

  always_comb begin
    state_next         = state;
    phase_next         = phase;
    count_high_next    = count_high;
    count_low_next     = count_low;
    frame_bytes_next   = frame_bytes;
    data_position_next = data_position;
    idle_ms_next       = idle_ms;
    in_fallback_next   = in_fallback;
    fill_addr_next     = fill_addr;
    fill_ch_next       = fill_ch;
    fill_init_next     = fill_init;
    out_valid_next     = out_valid && !out_ready;
    out_show_next      = out_show;
    out_fallback_next  = out_fallback;
    out_receiving_next = out_receiving;
    out_read_next      = out_read;
    ram_we             = 1'b0;
    ram_waddr          = fill_addr;
    ram_wdata          = fill_colour;
    done               = 1'b0;

    if (take && q_cmd.op == OP_BYTE) begin
      case (phase)
        PH_WAIT_D: begin
          phase_next = (q_cmd.data == CHAR_D) ? PH_WAIT_A2 : PH_WAIT_A;
        end
        PH_WAIT_A2: begin
          phase_next = (q_cmd.data == CHAR_LOWER_A) ? PH_HIGH : PH_WAIT_A;
        end
        PH_HIGH: begin
          count_high_next = q_cmd.data;
          phase_next      = PH_LOW;
        end
        PH_LOW: begin
          count_low_next = q_cmd.data;
          phase_next     = PH_CHECK;
        end
        PH_CHECK: begin
          if (q_cmd.data == (count_high ^ count_low ^ CHECK_XOR)) begin
            frame_bytes_next   = {1'b0, count_plus} + {count_plus, 1'b0};
            data_position_next = 18'd0;
            phase_next         = PH_DATA;
          end else begin
            phase_next = PH_WAIT_A;
          end
        end
        PH_DATA: begin
          if (32'(data_position) < STORE_BYTES) begin
            ram_we    = 1'b1;
            ram_waddr = AW'(data_position);
            ram_wdata = q_cmd.data;
          end
          data_position_next = pos_inc;
          if (pos_inc >= frame_bytes) begin
            done             = 1'b1;
            idle_ms_next     = 16'd0;
            in_fallback_next = 1'b0;
            phase_next       = PH_WAIT_A;
          end
        end
        default: begin
          phase_next = (q_cmd.data == CHAR_UPPER_A) ? PH_WAIT_D : PH_WAIT_A;
        end
      endcase
    end

    if (take && q_cmd.op == OP_TICK && idle_ms != 16'hFFFF) begin
      idle_ms_next = idle_ms + 16'd1;
    end

    fire = take && (q_cmd.op == OP_BYTE || q_cmd.op == OP_TICK)
           && !in_fallback_next && (idle_ms_next > cfg.timeout_ms);
    if (fire) begin
      in_fallback_next = 1'b1;
      state_next       = S_FILL;
      fill_addr_next   = '0;
      fill_ch_next     = 2'd0;
      fill_init_next   = 1'b0;
    end

    if (take) begin
      if (q_cmd.op == OP_READ && rd_in_range) begin
        state_next = S_READ;
      end else begin
        out_valid_next     = 1'b1;
        out_show_next      = done || fire;
        out_fallback_next  = in_fallback_next;
        out_receiving_next = (phase_next == PH_DATA);
        out_read_next      = 8'd0;
      end
    end

    case (state)
      S_READ: begin
        out_valid_next     = 1'b1;
        out_show_next      = 1'b0;
        out_fallback_next  = in_fallback;
        out_receiving_next = (phase == PH_DATA);
        out_read_next      = ram_rdata;
        state_next         = S_RUN;
      end
      S_FILL: begin
        ram_we         = 1'b1;
        fill_addr_next = fill_addr + AW'(1);
        fill_ch_next   = (fill_ch == 2'd2) ? 2'd0 : fill_ch + 2'd1;
        if (fill_addr == AW'(STORE_BYTES - 1)) begin
          state_next     = S_RUN;
          fill_init_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_FILL;
      phase         <= PH_WAIT_A;
      count_high    <= 8'd0;
      count_low     <= 8'd0;
      frame_bytes   <= 18'd0;
      data_position <= 18'd0;
      idle_ms       <= 16'd0;
      in_fallback   <= 1'b1;
      fill_addr     <= '0;
      fill_ch       <= 2'd0;
      fill_init     <= 1'b1;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      phase         <= phase_next;
      count_high    <= count_high_next;
      count_low     <= count_low_next;
      frame_bytes   <= frame_bytes_next;
      data_position <= data_position_next;
      idle_ms       <= idle_ms_next;
      in_fallback   <= in_fallback_next;
      fill_addr     <= fill_addr_next;
      fill_ch       <= fill_ch_next;
      fill_init     <= fill_init_next;
      out_valid     <= out_valid_next;
      out_show      <= out_show_next;
      out_fallback  <= out_fallback_next;
      out_receiving <= out_receiving_next;
      out_read      <= out_read_next;
    end
  end

endmodule

/* tb/sv/led_frame_serial_receiver_core_tb.sv */
// Self-checking testbench for led_frame_serial_receiver_core, built on lfrx_pkg.
// Drives serial bytes, ticks and store reads, predicts every result beat with
// a scoreboard class and checks the beats under random idling and stalls.
module led_frame_serial_receiver_core_tb;
  import lfrx_pkg::*;

  localparam int STORE_BYTES = 3 * LED_COUNT_DEF;
  localparam int SETTLE_CYCLES = STORE_BYTES + 16;
  localparam int STALL_LIMIT = 4 * STORE_BYTES + 2000;
  localparam int PHASE_ITEMS = 55;
  localparam int HOLD_CYCLES = 150;

  typedef enum logic [2:0] {
    HUNT_A,
    HUNT_D,
    HUNT_A2,
    TAKE_HIGH,
    TAKE_LOW,
    TAKE_CHECK,
    TAKE_DATA
  } parse_t;

  typedef struct {
    bit         show;
    bit         fallback;
    bit         receiving;
    logic [7:0] read_byte;
  } led_beat_t;

  class led_frame_checker;
    logic [15:0] timeout_ms;
    logic [7:0]  fill_color[3];
    parse_t      phase;
    logic [7:0]  count_hi;
    logic [7:0]  count_lo;
    logic [17:0] frame_len;
    logic [17:0] data_pos;
    logic [7:0]  store[STORE_BYTES];
    logic [15:0] idle_ms;
    bit          in_fallback;
    led_beat_t   expected_beats[$];
    int          errors;

    function new();
      timeout_ms = TIMEOUT_RST;
      fill_color[0] = RED_RST;
      fill_color[1] = GREEN_RST;
      fill_color[2] = BLUE_RST;
      phase = HUNT_A;
      count_hi = '0;
      count_lo = '0;
      frame_len = '0;
      data_pos = '0;
      idle_ms = '0;
      in_fallback = 1'b1;
      errors = 0;
      paint_fallback();
    endfunction

    function void set_reg(cfg_idx_t idx, logic [15:0] val);
      case (idx)
        CFG_TIMEOUT: timeout_ms = val;
        CFG_RED:     fill_color[0] = val[7:0];
        CFG_GREEN:   fill_color[1] = val[7:0];
        default:     fill_color[2] = val[7:0];
      endcase
    endfunction

    function void paint_fallback();
      for (int i = 0; i < STORE_BYTES; i++) store[i] = fill_color[i % 3];
    endfunction

    function bit take_serial(logic [7:0] c);
      bit done;
      done = 1'b0;
      case (phase)
        HUNT_D:  phase = (c == CHAR_D) ? HUNT_A2 : HUNT_A;
        HUNT_A2: phase = (c == CHAR_LOWER_A) ? TAKE_HIGH : HUNT_A;
        TAKE_HIGH: begin
          count_hi = c;
          phase = TAKE_LOW;
        end
        TAKE_LOW: begin
          count_lo = c;
          phase = TAKE_CHECK;
        end
        TAKE_CHECK: begin
          if (c == (count_hi ^ count_lo ^ CHECK_XOR)) begin
            frame_len = 18'((int'({count_hi, count_lo}) + 1) * 3);
            data_pos = '0;
            phase = TAKE_DATA;
          end else begin
            phase = HUNT_A;
          end
        end
        TAKE_DATA: begin
          if (data_pos < STORE_BYTES) store[data_pos] = c;
          data_pos = data_pos + 18'd1;
          if (data_pos >= frame_len) begin
            done = 1'b1;
            idle_ms = '0;
            in_fallback = 1'b0;
            phase = HUNT_A;
          end
        end
        default: phase = (c == CHAR_UPPER_A) ? HUNT_D : HUNT_A;
      endcase
      return done;
    endfunction

    function void accept_item(logic [1:0] kind, logic [7:0] value, logic [9:0] index);
      led_beat_t beat;
      beat.show = 1'b0;
      beat.read_byte = '0;
      if (kind == KIND_READ) begin
        if (index < STORE_BYTES) beat.read_byte = store[index];
      end else if (kind == KIND_BYTE || kind == KIND_TICK) begin
        if (kind == KIND_BYTE) beat.show = take_serial(value);
        else if (idle_ms != 16'hFFFF) idle_ms++;
        if (!in_fallback && idle_ms > timeout_ms) begin
          paint_fallback();
          beat.show = 1'b1;
          in_fallback = 1'b1;
        end
      end
      beat.fallback = in_fallback;
      beat.receiving = (phase == TAKE_DATA);
      expected_beats.push_back(beat);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= 30)
          $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_beat(logic [15:0] data);
      led_beat_t want;
      if (expected_beats.size() == 0) begin
        errors++;
        if (errors <= 30)
          $display("%0t: result beat %0h expected none actual one", $time, data);
        return;
      end
      want = expected_beats.pop_front();
      compare_field("show", want.show, data[0]);
      compare_field("fallback_active", want.fallback, data[1]);
      compare_field("receiving", want.receiving, data[2]);
      compare_field("read_byte", want.read_byte, data[10:3]);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // serial_byte[7:0], read_index[17:8], zero pad
  logic [1:0]  s_tuser;   // kind[1:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // show[0], fallback_active[1], receiving[2], read_byte[10:3]
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  led_frame_checker frame_check = new();
  int items_sent = 0;
  int send_idle_pct = 37;
  int recv_idle_pct = 84;
  bit hold_request = 1'b0;

  led_frame_serial_receiver_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic send_item(input logic [1:0] kind, input logic [7:0] value,
                           input logic [9:0] index);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {6'b0, index, value};
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    frame_check.accept_item(kind, value, index);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] value);
    send_item(KIND_BYTE, value, 10'($urandom));
  endtask

  task automatic send_tick();
    send_item(KIND_TICK, 8'($urandom), 10'($urandom));
  endtask

  task automatic send_read(input logic [9:0] index);
    send_item(KIND_READ, 8'($urandom), index);
  endtask

  task automatic send_header(input logic [7:0] hi, input logic [7:0] lo,
                             input logic [7:0] sum);
    send_byte(CHAR_UPPER_A);
    send_byte(CHAR_D);
    send_byte(CHAR_LOWER_A);
    send_byte(hi);
    send_byte(lo);
    send_byte(sum);
  endtask

  task automatic send_frame(input logic [15:0] count, input int tick_pct);
    send_header(count[15:8], count[7:0], count[15:8] ^ count[7:0] ^ CHECK_XOR);
    for (int i = 0; i < (int'(count) + 1) * 3; i++) begin
      if ($urandom_range(99) < tick_pct) send_tick();
      send_byte(8'($urandom));
    end
  endtask

  task automatic wait_settled();
    s_tvalid <= 1'b0;
    while (frame_check.expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [15:0] tmo, input logic [7:0] r,
                            input logic [7:0] g, input logic [7:0] b);
    logic [15:0] vals[4];
    vals = '{tmo, {8'h00, r}, {8'h00, g}, {8'h00, b}};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_data <= vals[i];
      frame_check.set_reg(cfg_idx_t'(i), vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input int budget);
    int stop_at;
    int pick;
    int cut;
    logic [7:0] hdr[6];
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        send_frame(16'($urandom_range(15)), 8);
      end else if (pick < 55) begin
        hdr = '{CHAR_UPPER_A, CHAR_D, CHAR_LOWER_A, 8'($urandom), 8'($urandom), 8'h00};
        hdr[5] = hdr[3] ^ hdr[4] ^ CHECK_XOR;
        cut = $urandom_range(1, 5);
        for (int i = 0; i < cut; i++) send_byte(hdr[i]);
        send_byte(hdr[cut] ^ 8'($urandom_range(1, 255)));
      end else if (pick < 70) begin
        repeat ($urandom_range(1, 20)) send_tick();
      end else if (pick < 85) begin
        if ($urandom_range(3) == 0) send_read(10'($urandom));
        else send_read(10'($urandom_range(STORE_BYTES - 1)));
      end else if (pick < 93) begin
        send_byte(8'($urandom));
      end else begin
        send_item(OP_NOP, 8'($urandom), 10'($urandom));
      end
    end
  endtask

  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) frame_check.check_beat(m_tdata);
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("led_frame_serial_receiver_core_tb NOT OK");
    $finish;
  end

  initial begin : stimulus
    logic [15:0] tmo_list[6];
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= KIND_BYTE;
    cfg_we <= 1'b0;
    cfg_index <= CFG_TIMEOUT;
    cfg_data <= '0;
    rst <= 1'b1;
    tmo_list = '{16'd1, 16'd65535, 16'd0, 16'd6, 16'd12, 16'd3};
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_read(10'd0);
    send_read(10'd2);
    send_read(10'(STORE_BYTES - 1));
    send_read(10'(STORE_BYTES));
    send_read(10'h3FF);
    send_item(OP_NOP, 8'hFF, 10'h3FF);
    send_tick();
    send_header(8'h00, 8'h00, CHECK_XOR);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hA5);
    send_read(10'd1);
    send_header(8'hFF, 8'hFF, 8'h00);
    send_byte(CHAR_UPPER_A);
    send_byte(8'h00);

    for (int p = 0; p < 6; p++) begin
      wait_settled();
      if (p == 0) write_regs(tmo_list[p], 8'h00, 8'h00, 8'h00);
      else if (p == 1) write_regs(tmo_list[p], 8'hFF, 8'hFF, 8'hFF);
      else write_regs(tmo_list[p], 8'($urandom), 8'($urandom), 8'($urandom));
      send_idle_pct = (p < 2) ? 37 : (p < 4) ? 84 : 0;
      recv_idle_pct = (p < 2) ? 84 : (p < 4) ? 37 : 0;
      // A frame one LED longer than the store fills it and drops the tail.
      if (p == 1) send_frame(16'(LED_COUNT_DEF), 0);
      if (p == 3) hold_request = 1'b1;
      run_random(PHASE_ITEMS);
    end

    wait_settled();

    if (frame_check.errors == 0 && frame_check.expected_beats.size() == 0)
      $display("led_frame_serial_receiver_core_tb OK");
    else
      $display("led_frame_serial_receiver_core_tb NOT OK");
    $finish;
  end

endmodule
